// ===== rtl/core/skt_pkg.sv =====
`default_nettype none

package skt_pkg;

  // Default table depth
  localparam int unsigned CAPACITY = 64;

  // Fixed field widths
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PAY_W    = 32;
  localparam int unsigned TOTAL_W  = 7;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Result transfer from the sequencer
  typedef struct packed {
    logic                 strobe;
    status_e              status;
    logic [TOTAL_W-1:0]   total;
  } resp_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_key_table_insert_delete.sv =====
`default_nettype none

// Sorted key table: holds up to CAPACITY records (signed 32-bit key, 32-bit
// payload) in ascending key order in two single-read-port RAMs. A command is
// taken when start is high and busy is low; its result (status, entry total)
// appears on the result ports for one cycle with result_valid_o and cannot be
// held off by the receiver. Full-table inserts and empty-table deletes answer
// in the cycle after the transfer. An insert walks down from the top of the
// table, shifting each entry whose key is not below the new key; a delete
// scans the whole held table. The RAM read port visits one entry per cycle
// during a walk, and its read data is registered. The stores need no clearing
// pass after reset: only held entries are ever read.
module sorted_key_table_insert_delete #(
  parameter int unsigned CAPACITY = skt_pkg::CAPACITY
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 operation_i,
  input  wire logic signed [skt_pkg::KEY_W-1:0]     record_key_i,
  input  wire logic        [skt_pkg::PAY_W-1:0]     record_payload_i,
  output logic                                      result_valid_o,
  output logic             [skt_pkg::STATUS_W-1:0]  status_o,
  output logic             [skt_pkg::TOTAL_W-1:0]   entry_total_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic                             rd_en;
  logic        [AW-1:0]             rd_addr;
  logic signed [skt_pkg::KEY_W-1:0] rd_key;
  logic        [skt_pkg::PAY_W-1:0] rd_pay;
  logic                             wr_en;
  logic        [AW-1:0]             wr_addr;
  logic        [skt_pkg::KEY_W-1:0] wr_key;
  logic        [skt_pkg::PAY_W-1:0] wr_pay;
  skt_pkg::resp_t                   resp;

  skt_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .operation_i      (operation_i),
    .record_key_i     (record_key_i),
    .record_payload_i (record_payload_i),
    .busy_o           (busy),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .rd_key_i         (rd_key),
    .rd_pay_i         (rd_pay),
    .wr_en_o          (wr_en),
    .wr_addr_o        (wr_addr),
    .wr_key_o         (wr_key),
    .wr_pay_o         (wr_pay),
    .resp_o           (resp)
  );

  // Key store
  skt_ram #(
    .WIDTH (skt_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_key),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_key)
  );

  // Payload store
  skt_ram #(
    .WIDTH (skt_pkg::PAY_W),
    .DEPTH (CAPACITY)
  ) u_payload_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_pay),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_pay)
  );

  assign result_valid_o = resp.strobe;
  assign status_o       = resp.status;
  assign entry_total_o  = resp.total;

  // A result only appears once the sequencer is back at rest
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result while busy");

  // Every accepted command either keeps the sequencer busy or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("accepted command made no progress");

  // A refused insert reports a full table
  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == skt_pkg::ST_FULL)) |->
      (entry_total_o == skt_pkg::TOTAL_W'(CAPACITY)))
    else $error("full status with wrong total");

  // An empty-table refusal reports zero records
  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == skt_pkg::ST_EMPTY)) |-> (entry_total_o == '0))
    else $error("empty status with non-zero total");

endmodule

`default_nettype wire

// ===== rtl/core/skt_ram.sv =====
`default_nettype none

module skt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/skt_seq.sv =====
`default_nettype none

module skt_seq #(
  parameter int unsigned CAPACITY = skt_pkg::CAPACITY,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic                               operation_i,
  input  wire logic signed [skt_pkg::KEY_W-1:0]   record_key_i,
  input  wire logic        [skt_pkg::PAY_W-1:0]   record_payload_i,
  output logic                                    busy_o,
  output logic                                    rd_en_o,
  output logic             [AW-1:0]               rd_addr_o,
  input  wire logic signed [skt_pkg::KEY_W-1:0]   rd_key_i,
  input  wire logic        [skt_pkg::PAY_W-1:0]   rd_pay_i,
  output logic                                    wr_en_o,
  output logic             [AW-1:0]               wr_addr_o,
  output logic             [skt_pkg::KEY_W-1:0]   wr_key_o,
  output logic             [skt_pkg::PAY_W-1:0]   wr_pay_o,
  output skt_pkg::resp_t                          resp_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_PLACE = 3'b100
  } state_e;

  state_e                              state_q, state_d;
  logic                                op_q, op_d;
  logic signed [skt_pkg::KEY_W-1:0]    key_q, key_d;
  logic        [skt_pkg::PAY_W-1:0]    pay_q, pay_d;
  logic        [CW-1:0]                count_q, count_d;
  logic        [AW-1:0]                ptr_q, ptr_d;
  logic                                issue_q, issue_d;
  logic                                rvld_q, rvld_d;
  logic        [AW-1:0]                eidx_q, eidx_d;
  logic                                found_q, found_d;
  logic        [AW-1:0]                pos_q, pos_d;
  skt_pkg::resp_t                      resp_q, resp_d;
  logic        [AW-1:0]                last_idx;
  logic                                hit;

  assign last_idx = AW'(count_q - CW'(1));
  assign hit      = !found_q && (rd_key_i == key_q);
  assign busy_o   = (state_q != S_IDLE);
  assign resp_o   = resp_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    pay_d       = pay_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    issue_d     = issue_q;
    rvld_d      = 1'b0;
    eidx_d      = eidx_q;
    found_d     = found_q;
    pos_d       = pos_q;
    resp_d      = '0;
    resp_d.status = skt_pkg::ST_DONE;
    rd_en_o     = 1'b0;
    rd_addr_o   = ptr_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = pos_q;
    wr_key_o    = key_q;
    wr_pay_o    = pay_q;

    unique case (state_q)
      S_IDLE: begin
        // Take the command and sort out the trivial cases at once
        if (start_i) begin
          op_d    = operation_i;
          key_d   = record_key_i;
          pay_d   = record_payload_i;
          found_d = 1'b0;
          if (operation_i == skt_pkg::OP_INSERT) begin
            if (count_q == CW'(CAPACITY)) begin
              resp_d.strobe = 1'b1;
              resp_d.status = skt_pkg::ST_FULL;
            end else if (count_q == '0) begin
              pos_d   = '0;
              state_d = S_PLACE;
            end else begin
              ptr_d   = last_idx;
              issue_d = 1'b1;
              state_d = S_WALK;
            end
          end else begin
            if (count_q == '0) begin
              resp_d.strobe = 1'b1;
              resp_d.status = skt_pkg::ST_EMPTY;
            end else begin
              ptr_d   = '0;
              issue_d = 1'b1;
              state_d = S_WALK;
            end
          end
        end
      end

      S_WALK: begin
        // Issue the next read: downwards for insert, upwards for delete
        if (issue_q) begin
          rd_en_o = 1'b1;
          rvld_d  = 1'b1;
          eidx_d  = ptr_q;
          if (op_q == skt_pkg::OP_INSERT) begin
            if (ptr_q == '0) begin
              issue_d = 1'b0;
            end else begin
              ptr_d = ptr_q - AW'(1);
            end
          end else begin
            if (ptr_q == last_idx) begin
              issue_d = 1'b0;
            end else begin
              ptr_d = ptr_q + AW'(1);
            end
          end
        end

        // Evaluate the entry read in the previous cycle
        if (rvld_q) begin
          if (op_q == skt_pkg::OP_INSERT) begin
            wr_en_o = 1'b1;
            wr_addr_o = eidx_q + AW'(1);
            if (rd_key_i >= key_q) begin
              // Shift this entry up one place
              wr_key_o = rd_key_i;
              wr_pay_o = rd_pay_i;
              if (eidx_q == '0) begin
                pos_d   = '0;
                issue_d = 1'b0;
                rvld_d  = 1'b0;
                state_d = S_PLACE;
              end
            end else begin
              // Drop the new record into the opened slot
              count_d       = count_q + CW'(1);
              resp_d.strobe = 1'b1;
              resp_d.status = skt_pkg::ST_DONE;
              issue_d       = 1'b0;
              rvld_d        = 1'b0;
              state_d       = S_IDLE;
            end
          end else begin
            // Close the gap behind the removed entry
            if (found_q) begin
              wr_en_o   = 1'b1;
              wr_addr_o = eidx_q - AW'(1);
              wr_key_o  = rd_key_i;
              wr_pay_o  = rd_pay_i;
            end
            found_d = found_q || hit;
            if (eidx_q == last_idx) begin
              resp_d.strobe = 1'b1;
              if (found_q || hit) begin
                count_d       = count_q - CW'(1);
                resp_d.status = skt_pkg::ST_DONE;
              end else begin
                resp_d.status = skt_pkg::ST_NOT_FOUND;
              end
              issue_d = 1'b0;
              rvld_d  = 1'b0;
              state_d = S_IDLE;
            end
          end
        end
      end

      S_PLACE: begin
        // Write the new record at the bottom of the table
        wr_en_o       = 1'b1;
        wr_addr_o     = pos_q;
        count_d       = count_q + CW'(1);
        resp_d.strobe = 1'b1;
        resp_d.status = skt_pkg::ST_DONE;
        state_d       = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    resp_d.total = skt_pkg::TOTAL_W'(count_d);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      issue_q <= 1'b0;
      rvld_q  <= 1'b0;
      found_q <= 1'b0;
      resp_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      issue_q <= issue_d;
      rvld_q  <= rvld_d;
      found_q <= found_d;
      resp_q  <= resp_d;
    end
  end

  // Command and walk registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    pay_q  <= pay_d;
    ptr_q  <= ptr_d;
    eidx_q <= eidx_d;
    pos_q  <= pos_d;
  end

endmodule

`default_nettype wire

// ===== dv/sorted_key_table_insert_delete_tb.sv =====
`timescale 1ns / 1ps

module sorted_key_table_insert_delete_tb;
  import skt_pkg::*;

  localparam int unsigned DEPTH      = skt_pkg::CAPACITY;
  localparam int unsigned ITEM_GOAL  = 950;
  localparam int unsigned QUIET_TAIL = 100;
  localparam int unsigned DRAIN_WAIT = DEPTH + 8;
  localparam int unsigned CYCLE_CAP  = 400000;

  typedef struct {
    op_e                       op;
    logic signed [KEY_W-1:0]   key;
    logic        [PAY_W-1:0]   payload;
    bit                        drain_first;
    bit                        quiet;
  } cmd_t;

  typedef struct {
    status_e                   status;
    logic        [TOTAL_W-1:0] total;
  } outcome_t;

  logic                        clk_i            = 1'b0;
  logic                        rst_ni           = 1'b0;
  logic                        start            = 1'b0;
  logic                        busy;
  logic                        operation_i      = 1'b0;
  logic signed [KEY_W-1:0]     record_key_i     = '0;
  logic        [PAY_W-1:0]     record_payload_i = '0;
  logic                        result_valid_o;
  logic        [STATUS_W-1:0]  status_o;
  logic        [TOTAL_W-1:0]   entry_total_o;

  // Commands waiting to go out, and outcomes waiting to come back
  cmd_t                        pending_cmds[$];
  outcome_t                    expected_results[$];

  // Ordered contents of the table as the checker sees them
  logic signed [KEY_W-1:0]     held_keys[$];
  logic        [PAY_W-1:0]     held_payloads[$];

  // Unordered keys the generator believes are held, to aim deletes at
  logic signed [KEY_W-1:0]     gen_keys[$];

  cmd_t                        in_flight;
  outcome_t                    want;
  bit                          took;
  bit                          start_nxt;
  int unsigned                 gap_left    = 0;
  int unsigned                 outstanding;
  int unsigned                 accepted_n  = 0;
  int unsigned                 seen_n      = 0;
  int unsigned                 fault_n     = 0;
  int unsigned                 cycle_n     = 0;

  sorted_key_table_insert_delete uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .record_key_i     (record_key_i),
    .record_payload_i (record_payload_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .entry_total_o    (entry_total_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one command to the shadow table and return its outcome
  function automatic outcome_t table_outcome(cmd_t c);
    outcome_t    r;
    int unsigned pos;
    pos = 0;
    if (c.op == OP_INSERT) begin
      if (held_keys.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // Go ahead of the first entry not below the new key
        while (pos < held_keys.size() && c.key > held_keys[pos]) pos++;
        held_keys.insert(pos, c.key);
        held_payloads.insert(pos, c.payload);
        r.status = ST_DONE;
      end
    end else if (held_keys.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      while (pos < held_keys.size() && held_keys[pos] != c.key) pos++;
      if (pos >= held_keys.size()) begin
        r.status = ST_NOT_FOUND;
      end else begin
        held_keys.delete(pos);
        held_payloads.delete(pos);
        r.status = ST_DONE;
      end
    end
    r.total = TOTAL_W'(held_keys.size());
    return r;
  endfunction

  // Key drawn from one of several shapes: full range, narrow pool, extremes
  function automatic logic signed [KEY_W-1:0] pick_key(int unsigned mode);
    logic signed [KEY_W-1:0] k;
    case (mode)
      1: k = KEY_W'(int'($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 5))
          0: k = 32'sh8000_0000;
          1: k = 32'sh7FFF_FFFF;
          2: k = 32'sh8000_0001;
          3: k = 32'sh7FFF_FFFE;
          4: k = '0;
          default: k = '1;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  task automatic queue_insert(logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] p, bit drain);
    cmd_t c;
    c.op          = OP_INSERT;
    c.key         = k;
    c.payload     = p;
    c.drain_first = drain;
    c.quiet       = 1'b0;
    pending_cmds.push_back(c);
    if (gen_keys.size() < DEPTH) gen_keys.push_back(k);
  endtask

  task automatic queue_delete(logic signed [KEY_W-1:0] k, bit drain);
    cmd_t        c;
    int unsigned i;
    c.op          = OP_DELETE;
    c.key         = k;
    c.payload     = $urandom;
    c.drain_first = drain;
    c.quiet       = 1'b0;
    pending_cmds.push_back(c);
    i = 0;
    while (i < gen_keys.size() && gen_keys[i] != k) i++;
    if (i < gen_keys.size()) gen_keys.delete(i);
  endtask

  task automatic queue_held_delete(bit drain);
    if (gen_keys.size() != 0) begin
      queue_delete(gen_keys[$urandom_range(0, gen_keys.size() - 1)], drain);
    end else begin
      queue_delete(pick_key(0), drain);
    end
  endtask

  // Fill to capacity, then knock on the full table a few times
  task automatic fill_episode(bit drain);
    int unsigned mode;
    bit          first;
    mode  = $urandom_range(0, 2);
    first = drain;
    while (gen_keys.size() < DEPTH) begin
      if ($urandom_range(0, 7) == 0) queue_held_delete(first);
      else queue_insert(pick_key(mode), $urandom, first);
      first = 1'b0;
    end
    repeat ($urandom_range(1, 3)) queue_insert(pick_key($urandom_range(0, 2)), $urandom, 1'b0);
  endtask

  // Remove everything, with stray misses, then delete from the empty table
  task automatic drain_episode(bit drain);
    bit first;
    first = drain;
    while (gen_keys.size() != 0) begin
      if ($urandom_range(0, 5) == 0) queue_delete(pick_key($urandom_range(0, 2)), first);
      else queue_held_delete(first);
      first = 1'b0;
    end
    repeat ($urandom_range(1, 2)) queue_delete(pick_key($urandom_range(0, 2)), first);
  endtask

  task automatic mixed_episode(bit drain);
    int unsigned r;
    bit          first;
    first = drain;
    repeat ($urandom_range(10, 40)) begin
      r = $urandom_range(0, 99);
      if (r < 55) queue_insert(pick_key($urandom_range(0, 2)), $urandom, first);
      else if (r < 85) queue_held_delete(first);
      else queue_delete(pick_key($urandom_range(0, 2)), first);
      first = 1'b0;
    end
  endtask

  // Build the command list, run it out and give the verdict
  initial begin
    // Directed: empty, single entry, extremes, duplicates, misses
    queue_delete('0, 1'b0);
    queue_insert(32'sd5, '0, 1'b0);
    queue_insert(32'sh7FFF_FFFF, '1, 1'b0);
    queue_insert(32'sh8000_0000, '0, 1'b0);
    queue_insert(32'sd5, 32'hA5A5_A5A5, 1'b0);
    queue_insert(-32'sd1, 32'h5A5A_5A5A, 1'b0);
    queue_insert('0, 32'h0000_0001, 1'b0);
    queue_insert(32'sd5, 32'h8000_0000, 1'b0);
    queue_delete(32'sd7, 1'b0);
    queue_delete(32'sd5, 1'b0);
    queue_delete(32'sh8000_0000, 1'b0);
    queue_delete(32'sh7FFF_FFFF, 1'b0);
    queue_delete(32'sd5, 1'b0);
    queue_delete(32'sd5, 1'b0);
    queue_delete(32'sd5, 1'b0);
    queue_delete(-32'sd1, 1'b0);
    queue_delete('0, 1'b0);
    queue_delete(32'sh7FFF_FFFF, 1'b0);
    queue_insert(32'sh8000_0001, 32'hFFFF_0000, 1'b1);
    queue_insert(32'sh7FFF_FFFE, 32'h0000_FFFF, 1'b0);
    queue_delete(32'sh8000_0001, 1'b0);
    queue_delete(32'sh7FFF_FFFE, 1'b0);

    // Random: one full fill and drain first, then a random mix of episodes
    fill_episode(1'b1);
    drain_episode(1'b0);
    while (pending_cmds.size() < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0, 1, 2: fill_episode($urandom_range(0, 1));
        3, 4:    drain_episode($urandom_range(0, 1));
        default: mixed_episode($urandom_range(0, 3) == 0);
      endcase
    end
    for (int unsigned i = 0; i < pending_cmds.size(); i++) begin
      if (i + QUIET_TAIL >= pending_cmds.size()) pending_cmds[i].quiet = 1'b1;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || start || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fault_n == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Driver: hold a command until transferred, then idle or launch the next
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        expected_results.push_back(table_outcome(in_flight));
        accepted_n <= accepted_n + 1;
        if (!in_flight.quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 16);
      end
      start_nxt = start && !took;
      if (!start_nxt) begin
        outstanding = accepted_n + (took ? 1 : 0) - seen_n;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain_first && outstanding != 0)) begin
          in_flight        = pending_cmds.pop_front();
          start_nxt        = 1'b1;
          operation_i      <= in_flight.op;
          record_key_i     <= in_flight.key;
          record_payload_i <= in_flight.payload;
        end
      end
      start <= start_nxt;
    end
  end

  // Monitor: compare every strobed result with the oldest outcome
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      seen_n <= seen_n + 1;
      if (expected_results.size() == 0) begin
        fault_n = fault_n + 1;
        if (fault_n <= 10) begin
          $display("unexpected result: status %0d total %0d", status_o, entry_total_o);
        end
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status || entry_total_o !== want.total) begin
          fault_n = fault_n + 1;
          if (fault_n <= 10) begin
            $display("mismatch: status exp %s got %0d, total exp %0d got %0d",
                     want.status.name(), status_o, want.total, entry_total_o);
          end
        end
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/core/skt_pkg.sv
rtl/core/skt_ram.sv
rtl/core/skt_seq.sv
rtl/core/sorted_key_table_insert_delete.sv
dv/sorted_key_table_insert_delete_tb.sv
